// ===== rtl/core/homogeneous_point_distance_defines.svh =====
// assertion macros for the homogeneous point distance block
`ifndef HOMOGENEOUS_POINT_DISTANCE_DEFINES_SVH
`define HOMOGENEOUS_POINT_DISTANCE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define HPD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hpd assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define HPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hpd assertion failed");

`endif

// ===== rtl/core/hpd_pkg.sv =====
// shared constants, pipeline word types and helpers for the point distance block
package hpd_pkg;

  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned EPS_W      = 16;
  localparam int unsigned OUT_W      = 48;
  localparam int unsigned LANES      = 6;
  localparam int unsigned AXES       = 3;

  localparam int unsigned NUM_W      = COORD_BITS + FRAC_BITS;
  localparam int unsigned DIV_STEPS  = NUM_W;
  localparam int unsigned PROD_W     = 2 * COORD_BITS;
  localparam int unsigned SUM_W      = 2 * COORD_BITS + 2;
  localparam int unsigned SQ_STEPS   = SUM_W / 2;
  localparam int unsigned ROOT_W     = SQ_STEPS;
  localparam int unsigned SQR_W      = COORD_BITS + 4;
  localparam int unsigned SQF_W      = SUM_W - FRAC_BITS;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  typedef struct packed {
    logic [NUM_W-1:0]      num;
    logic [COORD_BITS-1:0] rem;
    logic [NUM_W-1:0]      quo;
    logic [COORD_BITS-1:0] den;
    logic                  neg;
  } div_lane_t;

  typedef struct packed {
    logic                  valid;
    logic                  op;
    logic                  err;
    div_lane_t [LANES-1:0] lane;
  } div_word_t;

  typedef struct packed {
    logic              valid;
    logic              op;
    logic              err;
    logic [SUM_W-1:0]  rad;
    logic [SQR_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [OUT_W-1:0]  sq;
  } sqrt_word_t;

  // magnitude of a signed coordinate, exact for the most negative value
  function automatic logic [COORD_BITS-1:0] mag(input logic [COORD_BITS-1:0] v);
    mag = v[COORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  // signed quotient from magnitude and sign, saturated to the coordinate range
  function automatic logic [COORD_BITS-1:0] sat_quot(input logic [NUM_W-1:0] q,
                                                     input logic neg);
    logic [NUM_W-1:0] half;
    half = NUM_W'(1) << (COORD_BITS - 1);
    if (neg) begin
      sat_quot = (q >= half) ? half[COORD_BITS-1:0] : (~q[COORD_BITS-1:0] + 1'b1);
    end else begin
      sat_quot = (q >= half) ? (half[COORD_BITS-1:0] - 1'b1) : q[COORD_BITS-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/homogeneous_point_distance.sv =====
// top level: distance between two homogeneous points, fully pipelined
// Usage: each slave word carries two points (x, y, z, w each signed Q16.16) in
// tdata and the op bit in tuser (0 distance, 1 squared distance). Each word gives
// one master word: tdata holds the unsigned Q32.16 result, tuser flags a point
// whose |w| is not above the epsilon register (result zero then).
// The pipeline holds one entry register, 48 division cells (one quotient bit each,
// six lanes side by side), three square/sum registers, 33 square root cells (one
// root bit each) and the output register.
// Throughput is one word per cycle while the receiver takes words; the whole cell row advances together.
// When the receiver stalls with a word in the output register, the whole row
// holds and s_axis_tready drops with it until m_axis_tready returns.
// Reset clears all valid bits (the row empties) and sets epsilon to 66.
// cfg_we_i writes epsilon from cfg_wdata_i; write it only while the row is empty.
`include "homogeneous_point_distance_defines.svh"

module homogeneous_point_distance (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [hpd_pkg::EPS_W-1:0]                   cfg_wdata_i,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // first_x, first_y, first_z, first_w, second_x, second_y, second_z, second_w
  input  logic [8*hpd_pkg::COORD_BITS-1:0]            s_axis_tdata,
  // op
  input  logic                                        s_axis_tuser,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // distance_value
  output logic [hpd_pkg::OUT_W-1:0]                   m_axis_tdata,
  // not_point_error
  output logic                                        m_axis_tuser
);

  localparam int unsigned CB = hpd_pkg::COORD_BITS;

  logic                      en;
  logic [hpd_pkg::EPS_W-1:0] eps_q;
  logic                      out_valid_q;
  logic [hpd_pkg::OUT_W-1:0] out_data_q;
  logic                      out_err_q;

  hpd_pkg::div_word_t  div_w  [hpd_pkg::DIV_STEPS+1];
  hpd_pkg::sqrt_word_t sqrt_w [hpd_pkg::SQ_STEPS+1];
  hpd_pkg::div_word_t  entry_d;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= hpd_pkg::EPS_W'(66);
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    logic [CB-1:0] fw;
    logic [CB-1:0] sw;
    logic [CB-1:0] c;
    logic [CB-1:0] w;
    fw = s_axis_tdata[3*CB +: CB];
    sw = s_axis_tdata[7*CB +: CB];
    entry_d.valid = s_axis_tvalid;
    entry_d.op    = s_axis_tuser;
    entry_d.err   = (hpd_pkg::mag(fw) <= CB'(eps_q)) || (hpd_pkg::mag(sw) <= CB'(eps_q));
    for (int l = 0; l < hpd_pkg::LANES; l++) begin
      // lanes 0..2 take the first point, lanes 3..5 the second
      c = s_axis_tdata[((l / hpd_pkg::AXES) * 4 + (l % hpd_pkg::AXES)) * CB +: CB];
      w = (l < hpd_pkg::AXES) ? fw : sw;
      entry_d.lane[l].num = {hpd_pkg::mag(c), hpd_pkg::FRAC_BITS'(0)};
      entry_d.lane[l].rem = '0;
      entry_d.lane[l].quo = '0;
      entry_d.lane[l].den = hpd_pkg::mag(w);
      entry_d.lane[l].neg = c[CB-1] ^ w[CB-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_w[0].valid <= 1'b0;
    end else if (en) begin
      div_w[0] <= entry_d;
    end
  end

  for (genvar i = 0; i < hpd_pkg::DIV_STEPS; i++) begin : g_div
    hpd_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .word_i (div_w[i]),
      .word_o (div_w[i+1])
    );
  end

  hpd_square_stage u_square (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .word_i (div_w[hpd_pkg::DIV_STEPS]),
    .word_o (sqrt_w[0])
  );

  for (genvar i = 0; i < hpd_pkg::SQ_STEPS; i++) begin : g_sqrt
    hpd_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .word_i (sqrt_w[i]),
      .word_o (sqrt_w[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sqrt_w[hpd_pkg::SQ_STEPS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_err_q <= sqrt_w[hpd_pkg::SQ_STEPS].err;
      if (sqrt_w[hpd_pkg::SQ_STEPS].err) begin
        out_data_q <= '0;
      end else if (sqrt_w[hpd_pkg::SQ_STEPS].op) begin
        out_data_q <= sqrt_w[hpd_pkg::SQ_STEPS].sq;
      end else begin
        out_data_q <= hpd_pkg::OUT_W'(sqrt_w[hpd_pkg::SQ_STEPS].root);
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

  `HPD_ASSERT_IMPL(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
  `HPD_ASSERT_IMPL(a_ready_link, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  `HPD_ASSERT_NEXT(a_row_holds, m_axis_tvalid && !m_axis_tready, !s_axis_tready || m_axis_tready)

endmodule

// ===== rtl/core/hpd_div_cell.sv =====
// one restoring division step for all six coordinate lanes
module hpd_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  hpd_pkg::div_word_t word_i,
  output hpd_pkg::div_word_t word_o
);

  hpd_pkg::div_word_t word_d;
  hpd_pkg::div_word_t word_q;

  always_comb begin
    logic [hpd_pkg::COORD_BITS-1:0] shifted;
    logic                           ge;
    word_d = word_i;
    for (int l = 0; l < hpd_pkg::LANES; l++) begin
      // remainder stays below the divisor, so its top bit is always clear
      shifted = {word_i.lane[l].rem[hpd_pkg::COORD_BITS-2:0],
                 word_i.lane[l].num[hpd_pkg::NUM_W-1]};
      ge      = (shifted >= word_i.lane[l].den);
      word_d.lane[l].rem = ge ? (shifted - word_i.lane[l].den) : shifted;
      word_d.lane[l].num = {word_i.lane[l].num[hpd_pkg::NUM_W-2:0], 1'b0};
      word_d.lane[l].quo = {word_i.lane[l].quo[hpd_pkg::NUM_W-2:0], ge};
    end
  end

  // only the valid bit is reset, the data fields just follow the enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q.valid <= 1'b0;
    end else if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

// ===== rtl/core/hpd_square_stage.sv =====
// saturate quotients, take differences, square and sum them over three registers
module hpd_square_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  hpd_pkg::div_word_t  word_i,
  output hpd_pkg::sqrt_word_t word_o
);

  logic [1:0] valid_q;
  logic [1:0] op_q;
  logic [1:0] err_q;

  logic [hpd_pkg::COORD_BITS-1:0] diff_q [hpd_pkg::AXES];
  logic [hpd_pkg::PROD_W-1:0]     prod_q [hpd_pkg::AXES];
  hpd_pkg::sqrt_word_t            word_q;

  logic [hpd_pkg::COORD_BITS-1:0] diff_d [hpd_pkg::AXES];
  logic [hpd_pkg::SUM_W-1:0]      sum_d;
  logic [hpd_pkg::SQF_W-1:0]      sq_full;

  always_comb begin
    logic [hpd_pkg::COORD_BITS-1:0]      qa;
    logic [hpd_pkg::COORD_BITS-1:0]      qb;
    logic signed [hpd_pkg::COORD_BITS:0] a;
    logic signed [hpd_pkg::COORD_BITS:0] b;
    logic signed [hpd_pkg::COORD_BITS:0] d;
    for (int k = 0; k < hpd_pkg::AXES; k++) begin
      qa = hpd_pkg::sat_quot(word_i.lane[k].quo, word_i.lane[k].neg);
      qb = hpd_pkg::sat_quot(word_i.lane[k+hpd_pkg::AXES].quo,
                             word_i.lane[k+hpd_pkg::AXES].neg);
      a  = signed'({qa[hpd_pkg::COORD_BITS-1], qa});
      b  = signed'({qb[hpd_pkg::COORD_BITS-1], qb});
      d  = b - a;
      // the difference magnitude always fits the coordinate width unsigned
      diff_d[k] = d[hpd_pkg::COORD_BITS] ? hpd_pkg::COORD_BITS'(-d)
                                         : d[hpd_pkg::COORD_BITS-1:0];
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < hpd_pkg::AXES; k++) begin
      sum_d = sum_d + hpd_pkg::SUM_W'(prod_q[k]);
    end
    sq_full = sum_d[hpd_pkg::SUM_W-1:hpd_pkg::FRAC_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      word_q.valid <= 1'b0;
    end else if (en_i) begin
      valid_q      <= {valid_q[0], word_i.valid};
      word_q.valid <= valid_q[1];
      op_q         <= {op_q[0], word_i.op};
      err_q        <= {err_q[0], word_i.err};
      for (int k = 0; k < hpd_pkg::AXES; k++) begin
        diff_q[k] <= diff_d[k];
        prod_q[k] <= hpd_pkg::PROD_W'(diff_q[k]) * hpd_pkg::PROD_W'(diff_q[k]);
      end
      word_q.op   <= op_q[1];
      word_q.err  <= err_q[1];
      word_q.rad  <= sum_d;
      word_q.rem  <= '0;
      word_q.root <= '0;
      word_q.sq   <= (sq_full > hpd_pkg::SQF_W'(hpd_pkg::OUT_MAX)) ? hpd_pkg::OUT_MAX
                                                                     : hpd_pkg::OUT_W'(sq_full);
    end
  end

  assign word_o = word_q;

endmodule

// ===== rtl/core/hpd_sqrt_cell.sv =====
// one digit of the integer square root, two radicand bits per cell
module hpd_sqrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  hpd_pkg::sqrt_word_t word_i,
  output hpd_pkg::sqrt_word_t word_o
);

  hpd_pkg::sqrt_word_t word_d;
  hpd_pkg::sqrt_word_t word_q;

  always_comb begin
    logic [hpd_pkg::SQR_W-1:0] r2;
    logic [hpd_pkg::SQR_W-1:0] trial;
    logic                      ge;
    word_d = word_i;
    r2     = {word_i.rem[hpd_pkg::SQR_W-3:0], word_i.rad[hpd_pkg::SUM_W-1 -: 2]};
    trial  = hpd_pkg::SQR_W'({word_i.root, 2'b01});
    ge     = (r2 >= trial);
    word_d.rem  = ge ? (r2 - trial) : r2;
    word_d.rad  = {word_i.rad[hpd_pkg::SUM_W-3:0], 2'b00};
    word_d.root = {word_i.root[hpd_pkg::ROOT_W-2:0], ge};
  end

  // only the valid bit is reset, the data fields just follow the enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q.valid <= 1'b0;
    end else if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule
